/* src/wfsc_pkg.sv */
// Package for the wall-follow speed controller.
// Field widths, register indexes, item codes and fixed constants of the datapath.
// No dependencies.
package wfsc_pkg;

  localparam int SpeedW   = 20;
  localparam int AccelW   = 20;
  localparam int KpW      = 16;
  localparam int SampleW  = 12;
  localparam int DevW     = 13;
  localparam int ErrMagW  = 14;
  localparam int FlagsW   = 4;
  localparam int SlotW    = 2;
  localparam int CfgDataW = 48;
  localparam int CfgIdxW  = 3;

  localparam int ProdW       = SpeedW + KpW + ErrMagW;
  localparam int RoundShift  = 11;
  localparam int QuotW       = ProdW - RoundShift;
  localparam int RemW        = 7;
  localparam int SumW        = QuotW + 2;
  localparam int MulSteps    = KpW;
  localparam int DivSteps    = QuotW;
  localparam int StepCntW    = 6;

  localparam logic [ProdW-1:0]  RoundBias = ProdW'(128000);
  localparam logic [RemW:0]     DivConst  = 8'd125;
  localparam logic [SpeedW-1:0] SpeedMax  = '1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgAccel      = 3'd0,
    CfgMaxSpeed   = 3'd1,
    CfgMinSpeed   = 3'd2,
    CfgGainKp     = 3'd3,
    CfgWallEnable = 3'd4,
    CfgWallThr    = 3'd5,
    CfgCtrlThr    = 3'd6,
    CfgRefLevels  = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    OpSample = 1'b0,
    OpTick   = 1'b1
  } opcode_e;

  localparam logic [SlotW-1:0] SlotRight = 2'd0;
  localparam logic [SlotW-1:0] SlotLeft  = 2'd3;

  typedef struct packed {
    logic                 start;
    logic [SpeedW-1:0]    speed;
    logic [KpW-1:0]       gain;
    logic [ErrMagW-1:0]   err_mag;
  } corr_req_t;

endpackage

/* src/wfsc_in_if.sv */
// Input channel of the wall-follow speed controller: valid, ready and one item.
// Depends on wfsc_pkg for field widths.
interface wfsc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [wfsc_pkg::SampleW-1:0]  sample_value;

  modport source (output valid, output opcode, output sample_value, input ready);
  modport sink   (input valid, input opcode, input sample_value, output ready);
endinterface

/* src/wfsc_out_if.sv */
// Result channel of the wall-follow speed controller: valid, ready and one item.
// Depends on wfsc_pkg for field widths.
interface wfsc_out_if;
  logic                         valid;
  logic                         ready;
  logic [wfsc_pkg::SpeedW-1:0]  right_speed;
  logic [wfsc_pkg::SpeedW-1:0]  left_speed;
  logic [wfsc_pkg::FlagsW-1:0]  wall_flags;
  logic [wfsc_pkg::SlotW-1:0]   next_sensor;
  logic                         speed_updated;

  modport source (output valid, output right_speed, output left_speed, output wall_flags,
                  output next_sensor, output speed_updated, input ready);
  modport sink   (input valid, input right_speed, input left_speed, input wall_flags,
                  input next_sensor, input speed_updated, output ready);
endinterface

/* src/wfsc_corr_unit.sv */
// Bit-serial steering correction: round(speed * gain * err / 256000) in magnitude.
// Two shift-add multiply passes, a rounding add, then a restoring divide by 125.
// Depends on wfsc_pkg.
module wfsc_corr_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wfsc_pkg::corr_req_t           req_i,
  output logic                          done_o,
  output logic [wfsc_pkg::QuotW-1:0]    quot_o
);

  typedef enum logic [2:0] {
    UIdle,
    UMulA,
    UMulB,
    URound,
    UDiv
  } ustate_e;

  ustate_e                          state_q;
  logic [wfsc_pkg::ProdW-1:0]       mcand_q;
  logic [wfsc_pkg::KpW-1:0]         mplier_q;
  logic [wfsc_pkg::ProdW-1:0]       acc_q;
  logic [wfsc_pkg::QuotW-1:0]       quo_q;
  logic [wfsc_pkg::RemW-1:0]        rem_q;
  logic [wfsc_pkg::StepCntW-1:0]    cnt_q;
  logic                             done_q;

  logic [wfsc_pkg::ProdW-1:0]       acc_sum;
  logic [wfsc_pkg::ProdW-1:0]       rnd;
  logic [wfsc_pkg::RemW:0]          trial;
  logic                             trial_ge;
  logic [wfsc_pkg::RemW:0]          trial_sub;
  logic                             mul_last;
  logic                             div_last;

  assign acc_sum   = acc_q + (mplier_q[0] ? mcand_q : '0);
  assign rnd       = acc_q + wfsc_pkg::RoundBias;
  assign trial     = {rem_q, quo_q[wfsc_pkg::QuotW-1]};
  assign trial_ge  = (trial >= wfsc_pkg::DivConst);
  assign trial_sub = trial - wfsc_pkg::DivConst;
  assign mul_last  = (cnt_q == wfsc_pkg::StepCntW'(wfsc_pkg::MulSteps - 1));
  assign div_last  = (cnt_q == wfsc_pkg::StepCntW'(wfsc_pkg::DivSteps - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= UIdle;
      mcand_q  <= '0;
      mplier_q <= '0;
      acc_q    <= '0;
      quo_q    <= '0;
      rem_q    <= '0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        UIdle: begin
          if (req_i.start) begin
            mcand_q  <= wfsc_pkg::ProdW'(req_i.speed);
            mplier_q <= req_i.gain;
            acc_q    <= '0;
            cnt_q    <= '0;
            state_q  <= UMulA;
          end
        end
        UMulA: begin
          if (mul_last) begin
            mcand_q  <= acc_sum;
            mplier_q <= wfsc_pkg::KpW'(req_i.err_mag);
            acc_q    <= '0;
            cnt_q    <= '0;
            state_q  <= UMulB;
          end else begin
            acc_q    <= acc_sum;
            mcand_q  <= {mcand_q[wfsc_pkg::ProdW-2:0], 1'b0};
            mplier_q <= {1'b0, mplier_q[wfsc_pkg::KpW-1:1]};
            cnt_q    <= cnt_q + 1'b1;
          end
        end
        UMulB: begin
          acc_q    <= acc_sum;
          mcand_q  <= {mcand_q[wfsc_pkg::ProdW-2:0], 1'b0};
          mplier_q <= {1'b0, mplier_q[wfsc_pkg::KpW-1:1]};
          cnt_q    <= cnt_q + 1'b1;
          if (mul_last) begin
            state_q <= URound;
          end
        end
        URound: begin
          quo_q   <= rnd[wfsc_pkg::ProdW-1:wfsc_pkg::RoundShift];
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= UDiv;
        end
        UDiv: begin
          rem_q <= trial_ge ? trial_sub[wfsc_pkg::RemW-1:0] : trial[wfsc_pkg::RemW-1:0];
          quo_q <= {quo_q[wfsc_pkg::QuotW-2:0], trial_ge};
          cnt_q <= cnt_q + 1'b1;
          if (div_last) begin
            done_q  <= 1'b1;
            state_q <= UIdle;
          end
        end
        default: state_q <= UIdle;
      endcase
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == UIdle)
    else $error("correction start while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("correction done held longer than one cycle");

  a_done_from_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(state_q) == UDiv)
    else $error("correction done outside the divide pass");

endmodule

/* src/wall_follow_speed_controller_core.sv */
// Wall-follow speed controller: sensor rotation, base speed ramp and P steering.
// Depends on wfsc_pkg, wfsc_in_if, wfsc_out_if and wfsc_corr_unit.
//
//   channel   dir  handshake          payload
//   in_i      in   valid/ready        opcode, sample_value
//   out_o     out  valid/ready        right_speed, left_speed, wall_flags, next_sensor,
//                                     speed_updated
//   cfg       in   cfg_we_i (no wait) cfg_idx_i, cfg_data_i
//
// One item at a time. A sensor sample goes through SExec and SEmit to the result register;
// a control tick goes through SExec, SCorr (wall control only; it waits for the bit-serial
// correction unit: two 16-step shift-add passes, a 39-step divide by 125), SWheel and SEmit.
// A new item is accepted while the previous result still waits in the result register.
// Reset clears all state and registers; no clearing pass.
module wall_follow_speed_controller_core #(
  parameter int FLOOR_SPEED = 7680
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  wfsc_in_if.sink                           in_i,
  wfsc_out_if.source                        out_o,
  input  logic                              cfg_we_i,
  input  logic [wfsc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [wfsc_pkg::CfgDataW-1:0]     cfg_data_i
);

  typedef enum logic [2:0] {
    SIdle,
    SExec,
    SCorr,
    SWheel,
    SEmit
  } state_e;

  localparam logic signed [wfsc_pkg::SumW-1:0] FloorS =
    wfsc_pkg::SumW'(FLOOR_SPEED);
  localparam logic signed [wfsc_pkg::SumW-1:0] MaxS =
    wfsc_pkg::SumW'(wfsc_pkg::SpeedMax);

  // configuration
  logic [wfsc_pkg::AccelW-1:0]               accel_q;
  logic [wfsc_pkg::SpeedW-1:0]               max_q;
  logic [wfsc_pkg::SpeedW-1:0]               min_q;
  logic [wfsc_pkg::KpW-1:0]                  kp_q;
  logic                                      en_q;
  logic [3:0][wfsc_pkg::SampleW-1:0]         wth_q;
  logic [1:0][wfsc_pkg::SampleW-1:0]         cth_q;
  logic [1:0][wfsc_pkg::SampleW-1:0]         ref_q;

  // block state
  state_e                                    state_q;
  logic                                      op_q;
  logic [wfsc_pkg::SampleW-1:0]              sample_q;
  logic [wfsc_pkg::SpeedW-1:0]               base_q;
  logic [wfsc_pkg::SlotW-1:0]                slot_q;
  logic [wfsc_pkg::FlagsW-1:0]               wall_q;
  logic signed [1:0][wfsc_pkg::DevW-1:0]     dev_q;
  logic [1:0]                                inctl_q;
  logic [1:0][wfsc_pkg::SpeedW-1:0]          wheel_q;
  logic                                      use_corr_q;
  logic                                      neg_q;

  // result register
  logic                                      out_valid_q;
  logic [wfsc_pkg::SpeedW-1:0]               out_rs_q;
  logic [wfsc_pkg::SpeedW-1:0]               out_ls_q;
  logic [wfsc_pkg::FlagsW-1:0]               out_flags_q;
  logic [wfsc_pkg::SlotW-1:0]                out_next_q;
  logic                                      out_upd_q;

  logic                                      in_take;
  logic                                      emit_load;
  logic                                      side_sel;
  logic                                      is_side;
  logic                                      wall_hit;
  logic                                      ctl_hit;
  logic signed [wfsc_pkg::DevW-1:0]          dev_new;
  logic signed [wfsc_pkg::SpeedW+1:0]        speed_sum;
  logic signed [wfsc_pkg::SpeedW+1:0]        speed_hi;
  logic [wfsc_pkg::SpeedW-1:0]               speed_clamp;
  logic signed [wfsc_pkg::ErrMagW-1:0]       err_diff;
  logic signed [wfsc_pkg::ErrMagW:0]         err_full;
  logic signed [wfsc_pkg::ErrMagW:0]         err_abs;
  wfsc_pkg::corr_req_t                       corr_req;
  logic                                      corr_done;
  logic [wfsc_pkg::QuotW-1:0]                corr_quot;
  logic signed [wfsc_pkg::SumW-1:0]          corr_val;
  logic signed [wfsc_pkg::SumW-1:0]          base_ext;
  logic signed [wfsc_pkg::SumW-1:0]          right_sum;
  logic signed [wfsc_pkg::SumW-1:0]          left_sum;

  function automatic logic [wfsc_pkg::SpeedW-1:0] finish_wheel(
    input logic signed [wfsc_pkg::SumW-1:0] v
  );
    logic signed [wfsc_pkg::SumW-1:0] t;
    t = v;
    if (t < FloorS) t = FloorS;
    if (t > MaxS) t = MaxS;
    return t[wfsc_pkg::SpeedW-1:0];
  endfunction

  assign in_i.ready = (state_q == SIdle);
  assign in_take    = in_i.valid && in_i.ready;
  assign emit_load  = (state_q == SEmit) && (!out_valid_q || out_o.ready);

  // sensor sample
  assign is_side  = (slot_q == wfsc_pkg::SlotRight) || (slot_q == wfsc_pkg::SlotLeft);
  assign side_sel = (slot_q == wfsc_pkg::SlotLeft);
  assign wall_hit = (sample_q > wth_q[slot_q]);
  assign ctl_hit  = (sample_q > cth_q[side_sel]);
  assign dev_new  = $signed({1'b0, sample_q}) - $signed({1'b0, ref_q[side_sel]});

  // control tick: ramp and clamp
  assign speed_sum = $signed({2'b00, base_q})
                   + $signed({{2{accel_q[wfsc_pkg::AccelW-1]}}, accel_q});
  assign speed_hi  = (speed_sum > $signed({2'b00, max_q})) ? $signed({2'b00, max_q})
                                                           : speed_sum;
  assign speed_clamp = (speed_hi < $signed({2'b00, min_q})) ? min_q
                                                            : speed_hi[wfsc_pkg::SpeedW-1:0];

  assign err_diff = $signed({dev_q[0][wfsc_pkg::DevW-1], dev_q[0]})
                  - $signed({dev_q[1][wfsc_pkg::DevW-1], dev_q[1]});
  assign err_full = (inctl_q[0] && inctl_q[1]) ? $signed({err_diff[wfsc_pkg::ErrMagW-1],
                                                          err_diff})
                                               : $signed({err_diff, 1'b0});
  assign err_abs  = err_full[wfsc_pkg::ErrMagW] ? -err_full : err_full;

  assign corr_req.start   = (state_q == SExec) && (op_q == wfsc_pkg::OpTick) && en_q;
  assign corr_req.speed   = speed_clamp;
  assign corr_req.gain    = kp_q;
  assign corr_req.err_mag = err_abs[wfsc_pkg::ErrMagW-1:0];

  wfsc_corr_unit u_corr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (corr_req),
    .done_o (corr_done),
    .quot_o (corr_quot)
  );

  // wheel commands
  assign base_ext  = $signed({{(wfsc_pkg::SumW - wfsc_pkg::SpeedW){1'b0}}, base_q});
  assign corr_val  = !use_corr_q ? '0
                   : neg_q       ? -$signed({2'b00, corr_quot})
                                 :  $signed({2'b00, corr_quot});
  assign right_sum = base_ext + corr_val;
  assign left_sum  = base_ext - corr_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q <= '0;
      max_q   <= '0;
      min_q   <= '0;
      kp_q    <= '0;
      en_q    <= 1'b0;
      wth_q   <= '0;
      cth_q   <= '0;
      ref_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (wfsc_pkg::cfg_idx_e'(cfg_idx_i))
        wfsc_pkg::CfgAccel:      accel_q <= cfg_data_i[wfsc_pkg::AccelW-1:0];
        wfsc_pkg::CfgMaxSpeed:   max_q   <= cfg_data_i[wfsc_pkg::SpeedW-1:0];
        wfsc_pkg::CfgMinSpeed:   min_q   <= cfg_data_i[wfsc_pkg::SpeedW-1:0];
        wfsc_pkg::CfgGainKp:     kp_q    <= cfg_data_i[wfsc_pkg::KpW-1:0];
        wfsc_pkg::CfgWallEnable: en_q    <= cfg_data_i[0];
        wfsc_pkg::CfgWallThr:    wth_q   <= cfg_data_i[4*wfsc_pkg::SampleW-1:0];
        wfsc_pkg::CfgCtrlThr:    cth_q   <= cfg_data_i[2*wfsc_pkg::SampleW-1:0];
        wfsc_pkg::CfgRefLevels:  ref_q   <= cfg_data_i[2*wfsc_pkg::SampleW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      op_q        <= wfsc_pkg::OpSample;
      sample_q    <= '0;
      base_q      <= '0;
      slot_q      <= '0;
      wall_q      <= '0;
      dev_q       <= '0;
      inctl_q     <= '0;
      wheel_q     <= '0;
      use_corr_q  <= 1'b0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_rs_q    <= '0;
      out_ls_q    <= '0;
      out_flags_q <= '0;
      out_next_q  <= '0;
      out_upd_q   <= 1'b0;
    end else begin
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        SIdle: begin
          if (in_take) begin
            op_q     <= in_i.opcode;
            sample_q <= in_i.sample_value;
            state_q  <= SExec;
          end
        end
        SExec: begin
          if (op_q == wfsc_pkg::OpTick) begin
            base_q     <= speed_clamp;
            use_corr_q <= en_q;
            neg_q      <= err_full[wfsc_pkg::ErrMagW];
            state_q    <= en_q ? SCorr : SWheel;
          end else begin
            wall_q[slot_q] <= wall_hit;
            if (is_side) begin
              dev_q[side_sel]   <= ctl_hit ? dev_new : '0;
              inctl_q[side_sel] <= ctl_hit;
            end
            slot_q  <= slot_q + 1'b1;
            state_q <= SEmit;
          end
        end
        SCorr: begin
          if (corr_done) begin
            state_q <= SWheel;
          end
        end
        SWheel: begin
          wheel_q[0] <= finish_wheel(right_sum);
          wheel_q[1] <= finish_wheel(left_sum);
          state_q    <= SEmit;
        end
        SEmit: begin
          if (emit_load) begin
            out_rs_q    <= wheel_q[0];
            out_ls_q    <= wheel_q[1];
            out_flags_q <= wall_q;
            out_next_q  <= slot_q;
            out_upd_q   <= op_q;
            state_q     <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.right_speed   = out_rs_q;
  assign out_o.left_speed    = out_ls_q;
  assign out_o.wall_flags    = out_flags_q;
  assign out_o.next_sensor   = out_next_q;
  assign out_o.speed_updated = out_upd_q;

  a_slot_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SExec && op_q == wfsc_pkg::OpSample) |=> slot_q == $past(slot_q) + 2'd1)
    else $error("sensor slot did not advance on a sample");

  a_done_in_corr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    corr_done |-> state_q == SCorr)
    else $error("correction finished outside the wait state");

  a_emit_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEmit && out_valid_q && !out_o.ready) |=> state_q == SEmit)
    else $error("pending result overwritten");

  a_wheel_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_rs_q == '0 || 32'(out_rs_q) >= FLOOR_SPEED))
    else $error("right wheel command below floor");

endmodule

/* tb/sv/wall_follow_speed_controller_core_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for wall_follow_speed_controller_core: random and directed items
// against an in-bench predictor. Needs wfsc_pkg, wfsc_in_if, wfsc_out_if and the core.
module wall_follow_speed_controller_core_test;

  localparam int FloorSpeed = 7680;

  typedef struct {
    wfsc_pkg::opcode_e                 op;
    logic [wfsc_pkg::SampleW-1:0]      sample;
  } sensor_item_t;

  typedef struct packed {
    logic [wfsc_pkg::SpeedW-1:0] right_speed;
    logic [wfsc_pkg::SpeedW-1:0] left_speed;
    logic [wfsc_pkg::FlagsW-1:0] wall_flags;
    logic [wfsc_pkg::SlotW-1:0]  next_sensor;
    logic                        speed_updated;
  } wheel_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                          drv_valid = 1'b0;
  logic                          drv_opcode = 1'b0;
  logic [wfsc_pkg::SampleW-1:0]  drv_sample = '0;
  logic                          drv_ready = 1'b0;
  logic                          cfg_we = 1'b0;
  wfsc_pkg::cfg_idx_e            cfg_idx = wfsc_pkg::CfgAccel;
  logic [wfsc_pkg::CfgDataW-1:0] cfg_data = '0;

  wfsc_in_if  in_ch ();
  wfsc_out_if out_ch ();

  assign in_ch.valid        = drv_valid;
  assign in_ch.opcode       = drv_opcode;
  assign in_ch.sample_value = drv_sample;
  assign out_ch.ready       = drv_ready;

  wall_follow_speed_controller_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor settings and state
  logic signed [wfsc_pkg::AccelW-1:0] accel_r = '0;
  logic [wfsc_pkg::SpeedW-1:0]        max_speed_r = '0;
  logic [wfsc_pkg::SpeedW-1:0]        min_speed_r = '0;
  logic [wfsc_pkg::KpW-1:0]           gain_kp_r = '0;
  logic                               wall_ctrl_r = 1'b0;
  logic [47:0]                        wall_thr_r = '0;
  logic [23:0]                        ctrl_thr_r = '0;
  logic [23:0]                        ref_lvl_r = '0;

  logic [wfsc_pkg::SpeedW-1:0]      base_speed_m = '0;
  logic [wfsc_pkg::SlotW-1:0]       slot_m = '0;
  logic [wfsc_pkg::FlagsW-1:0]      walls_m = '0;
  logic signed [wfsc_pkg::DevW-1:0] dev_m [2] = '{default: '0};
  logic                             in_ctrl_m [2] = '{default: 1'b0};
  logic [wfsc_pkg::SpeedW-1:0]      wheel_m [2] = '{default: '0};

  sensor_item_t items_to_send_q[$];
  wheel_cmd_t   expected_cmds_q[$];
  int           errors = 0;
  int           send_idle_pct = 28;
  int           recv_idle_pct = 69;
  bit           stall_armed = 1'b0;
  bit           stall_done = 1'b0;
  int           hold_left = 0;

  function automatic logic [wfsc_pkg::SpeedW-1:0] floor_and_saturate(longint v);
    if (v < longint'(FloorSpeed)) v = longint'(FloorSpeed);
    if (v > longint'(wfsc_pkg::SpeedMax)) v = longint'(wfsc_pkg::SpeedMax);
    return v[wfsc_pkg::SpeedW-1:0];
  endfunction

  function automatic wheel_cmd_t advance_controller(wfsc_pkg::opcode_e op,
                                                    logic [wfsc_pkg::SampleW-1:0] val);
    wheel_cmd_t res;
    longint     s;
    longint     err;
    longint     prod;
    longint     mag;
    longint     corr;
    int         side;
    if (op == wfsc_pkg::OpTick) begin
      s = longint'(base_speed_m) + longint'(accel_r);
      if (s > longint'(max_speed_r)) s = longint'(max_speed_r);
      if (s < longint'(min_speed_r)) s = longint'(min_speed_r);
      base_speed_m = s[wfsc_pkg::SpeedW-1:0];
      corr = 0;
      if (wall_ctrl_r) begin
        err = longint'(dev_m[0]) - longint'(dev_m[1]);
        if (!(in_ctrl_m[0] && in_ctrl_m[1])) err = err * 2;
        prod = s * longint'(gain_kp_r) * err;
        mag = (prod < 0) ? -prod : prod;
        corr = (mag + 128000) / 256000;
        if (prod < 0) corr = -corr;
      end
      wheel_m[0] = floor_and_saturate(s + corr);
      wheel_m[1] = floor_and_saturate(s - corr);
    end else begin
      walls_m[slot_m] = (val > wall_thr_r[12*slot_m +: 12]);
      if (slot_m == wfsc_pkg::SlotRight || slot_m == wfsc_pkg::SlotLeft) begin
        side = (slot_m == wfsc_pkg::SlotLeft) ? 1 : 0;
        if (val > ctrl_thr_r[12*side +: 12]) begin
          dev_m[side] = 13'(int'(val) - int'(ref_lvl_r[12*side +: 12]));
          in_ctrl_m[side] = 1'b1;
        end else begin
          dev_m[side] = '0;
          in_ctrl_m[side] = 1'b0;
        end
      end
      slot_m = slot_m + 2'd1;
    end
    res.right_speed   = wheel_m[0];
    res.left_speed    = wheel_m[1];
    res.wall_flags    = walls_m;
    res.next_sensor   = slot_m;
    res.speed_updated = (op == wfsc_pkg::OpTick);
    return res;
  endfunction

  task automatic write_reg(wfsc_pkg::cfg_idx_e idx, logic [wfsc_pkg::CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      wfsc_pkg::CfgAccel:      accel_r = data[wfsc_pkg::AccelW-1:0];
      wfsc_pkg::CfgMaxSpeed:   max_speed_r = data[wfsc_pkg::SpeedW-1:0];
      wfsc_pkg::CfgMinSpeed:   min_speed_r = data[wfsc_pkg::SpeedW-1:0];
      wfsc_pkg::CfgGainKp:     gain_kp_r = data[wfsc_pkg::KpW-1:0];
      wfsc_pkg::CfgWallEnable: wall_ctrl_r = data[0];
      wfsc_pkg::CfgWallThr:    wall_thr_r = data[47:0];
      wfsc_pkg::CfgCtrlThr:    ctrl_thr_r = data[23:0];
      wfsc_pkg::CfgRefLevels:  ref_lvl_r = data[23:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(logic [19:0] accel, logic [19:0] vmax, logic [19:0] vmin,
                               logic [15:0] kp, logic en, logic [47:0] wth,
                               logic [23:0] cth, logic [23:0] refs);
    write_reg(wfsc_pkg::CfgAccel, 48'(accel));
    write_reg(wfsc_pkg::CfgMaxSpeed, 48'(vmax));
    write_reg(wfsc_pkg::CfgMinSpeed, 48'(vmin));
    write_reg(wfsc_pkg::CfgGainKp, 48'(kp));
    write_reg(wfsc_pkg::CfgWallEnable, 48'(en));
    write_reg(wfsc_pkg::CfgWallThr, wth);
    write_reg(wfsc_pkg::CfgCtrlThr, 48'(cth));
    write_reg(wfsc_pkg::CfgRefLevels, 48'(refs));
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_item(wfsc_pkg::opcode_e op, logic [wfsc_pkg::SampleW-1:0] val);
    sensor_item_t it;
    it.op = op;
    it.sample = val;
    items_to_send_q.push_back(it);
  endtask

  function automatic logic [wfsc_pkg::SampleW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return wfsc_pkg::SampleW'($urandom);
    endcase
  endfunction

  task automatic queue_random(int n);
    int cnt;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 9) < 7) begin
        repeat (4) queue_item(wfsc_pkg::OpSample, pick_sample());
        queue_item(wfsc_pkg::OpTick, pick_sample());
        cnt += 5;
      end else begin
        queue_item(wfsc_pkg::opcode_e'($urandom_range(0, 1)), pick_sample());
        cnt++;
      end
    end
  endtask

  task automatic wait_drained();
    while (items_to_send_q.size() != 0 || drv_valid || expected_cmds_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic check_field(string name, logic [wfsc_pkg::SpeedW-1:0] want,
                             logic [wfsc_pkg::SpeedW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // When the line is free, offer the next item unless a random idle slot is drawn
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
    end else if (!drv_valid || in_ch.ready) begin
      if (items_to_send_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        drv_valid  <= 1'b1;
        drv_opcode <= items_to_send_q[0].op;
        drv_sample <= items_to_send_q[0].sample;
        void'(items_to_send_q.pop_front());
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (stall_armed && !stall_done) begin
      stall_done = 1'b1;
      hold_left  = 400;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      drv_ready <= 1'b0;
    end else begin
      drv_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    wheel_cmd_t got;
    wheel_cmd_t want;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        got.right_speed   = out_ch.right_speed;
        got.left_speed    = out_ch.left_speed;
        got.wall_flags    = out_ch.wall_flags;
        got.next_sensor   = out_ch.next_sensor;
        got.speed_updated = out_ch.speed_updated;
        if (expected_cmds_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, got);
          errors++;
        end else begin
          want = expected_cmds_q.pop_front();
          check_field("right_speed", want.right_speed, got.right_speed);
          check_field("left_speed", want.left_speed, got.left_speed);
          check_field("wall_flags", 20'(want.wall_flags), 20'(got.wall_flags));
          check_field("next_sensor", 20'(want.next_sensor), 20'(got.next_sensor));
          check_field("speed_updated", 20'(want.speed_updated), 20'(got.speed_updated));
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_cmds_q.push_back(advance_controller(wfsc_pkg::opcode_e'(in_ch.opcode),
                                                     in_ch.sample_value));
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_item(wfsc_pkg::OpSample, 12'd0);
    queue_item(wfsc_pkg::OpSample, 12'hFFF);
    queue_item(wfsc_pkg::OpSample, 12'd1);
    queue_item(wfsc_pkg::OpSample, 12'hFFF);
    queue_item(wfsc_pkg::OpTick, 12'hABC);
    wait_drained();

    load_settings(20'h7FFFF, 20'hFFFFF, 20'd0, 16'hFFFF, 1'b1, 48'd0, 24'd0, 24'd0);
    queue_item(wfsc_pkg::OpSample, 12'hFFF);
    queue_item(wfsc_pkg::OpSample, 12'd0);
    queue_item(wfsc_pkg::OpSample, 12'hFFF);
    queue_item(wfsc_pkg::OpSample, 12'd0);
    repeat (3) queue_item(wfsc_pkg::OpTick, 12'hFFF);
    wait_drained();

    load_settings(20'h80000, 20'd1000, 20'd5000, 16'd256, 1'b1, 48'hFFF_FFF_FFF_FFF,
                  24'd0, 24'hFFF_FFF);
    repeat (4) queue_item(wfsc_pkg::OpSample, 12'hFFF);
    queue_item(wfsc_pkg::OpTick, 12'd0);
    queue_item(wfsc_pkg::OpSample, 12'd2048);
    queue_item(wfsc_pkg::OpSample, 12'd0);
    queue_item(wfsc_pkg::OpSample, 12'd0);
    queue_item(wfsc_pkg::OpSample, 12'hFFF);
    queue_item(wfsc_pkg::OpTick, 12'h555);
    wait_drained();

    load_settings(20'h80000, 20'hFFFFF, 20'd0, 16'd0, 1'b0, 48'd0, 24'hFFF_FFF, 24'd0);
    queue_item(wfsc_pkg::OpTick, 12'd0);
    queue_item(wfsc_pkg::OpTick, 12'hFFF);
    queue_item(wfsc_pkg::OpSample, 12'hFFF);
    queue_item(wfsc_pkg::OpSample, 12'd0);
    wait_drained();

    for (int ph = 0; ph < 9; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 28;
        recv_idle_pct = 69;
      end else if (ph < 6) begin
        send_idle_pct = 69;
        recv_idle_pct = 28;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      load_settings($urandom_range(0, 3) == 0 ? 20'($urandom)
                                              : 20'($urandom_range(0, 4095) - 2048),
                    $urandom_range(0, 3) == 0 ? 20'hFFFFF : 20'($urandom_range(8000, 300000)),
                    $urandom_range(0, 4) == 0 ? 20'($urandom) : 20'($urandom_range(0, 6000)),
                    16'($urandom),
                    $urandom_range(0, 3) != 0,
                    {16'($urandom), 32'($urandom)},
                    {12'($urandom_range(0, 2047)), 12'($urandom_range(0, 2047))},
                    24'($urandom));
      if (ph == 1) stall_armed = 1'b1;
      queue_random(147);
      wait_drained();
    end

    repeat (100) @(posedge clk_i);
    if (errors == 0 && expected_cmds_q.size() == 0) begin
      $display("[wall_follow_speed_controller_core] OK");
    end else begin
      $display("[wall_follow_speed_controller_core] ERROR");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("[wall_follow_speed_controller_core] ERROR");
    $finish;
  end

endmodule

/* filelist.f */
src/wfsc_pkg.sv
src/wfsc_in_if.sv
src/wfsc_out_if.sv
src/wfsc_corr_unit.sv
src/wall_follow_speed_controller_core.sv
tb/sv/wall_follow_speed_controller_core_test.sv
